FILE: rtl/nnt_pkg.sv
// Shared types and fixed widths for the nearest-neighbour tour block.
// No dependencies; imported by nearest_neighbor_tour_core.
`default_nettype none

package nnt_pkg;

  // Fixed field widths of the interface words.
  localparam int CITY_W  = 5;
  localparam int COUNT_W = 6;
  localparam int LEN_W   = 21;

  // Value of the city count register after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  // Tour sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_WAIT,
    ST_COMMIT,
    ST_RET,
    ST_RET_EMIT
  } nnt_state_t;

endpackage

`default_nettype wire

FILE: rtl/nearest_neighbor_tour_core.sv
// Greedy nearest-neighbour tour over a stored upper-triangle distance matrix.
// Depends on nnt_pkg for widths and the sequencer state type.
//
// Use: matrix entries arrive as words on the input channel (in_valid/in_stall),
// one per cycle while the block is idle. Only entries with row below column
// are written to the distance memory. A word with last_entry set is stored if
// it qualifies and then starts a tour from city 0. The block then stalls its
// input and emits one word per visited city on the output channel
// (out_valid/out_stall), followed by a final word for the return to city 0
// with last_city and tour_length set. The first city (city 0) is placed in
// the output register from the start state once that register is free. Each
// further city takes a scan state (one memory read per candidate city), a
// wait state for the registered read, and a commit state. The single read
// port of the distance memory sets the length of the scan.
// The output register lets the block run on while a word waits; a stalled
// receiver holds the sequencer only when a new word must be placed.
// Reset (rst, synchronous) returns to idle, empties the output register and
// sets the city count to 32. The distance memory is not cleared: every entry
// must be written before a tour reads it. The user writes city_count through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none

module nearest_neighbor_tour_core
  import nnt_pkg::*;
#(
  parameter int MAX_CITIES = 32,
  parameter int DIST_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration
  input  wire logic                 cfg_we,
  input  wire logic [COUNT_W-1:0]   cfg_wdata,
  // Matrix entry channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CITY_W-1:0]    row_city,
  input  wire logic [CITY_W-1:0]    col_city,
  input  wire logic [DIST_BITS-1:0] distance,
  input  wire logic                 last_entry,
  // Tour channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CITY_W-1:0]         city,
  output logic [LEN_W-1:0]          tour_length,
  output logic                      last_city
);

  localparam int IDX_W  = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
  localparam int ADDR_W = $clog2(DEPTH);

  // Distance memory, one synchronous read port.
  logic [DIST_BITS-1:0] mem [DEPTH];
  logic [DIST_BITS-1:0] rd_data;

  // Configuration and sequencer registers.
  logic [COUNT_W-1:0]    city_count;
  nnt_state_t            state, state_next;
  logic [MAX_CITIES-1:0] visited;
  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      cand;
  logic [CNT_W-1:0]      step;
  logic [LEN_W-1:0]      running_length;
  logic                  found;
  logic [IDX_W-1:0]      best;
  logic [DIST_BITS-1:0]  bestd;
  logic                  s1_valid;
  logic                  s1_elig;
  logic [IDX_W-1:0]      s1_cand;

  // Combinational control.
  logic                  in_accept;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  rd_en;
  logic [IDX_W-1:0]      pair_other;
  logic [IDX_W-1:0]      pair_lo, pair_hi;
  logic [ADDR_W-1:0]     rd_addr;
  logic [CNT_W-1:0]      n;
  logic                  cand_last;
  logic                  out_free;
  logic                  emit;
  logic [CITY_W-1:0]     emit_city;
  logic [LEN_W-1:0]      emit_len;
  logic                  emit_last;
  logic [LEN_W-1:0]      ret_len;
  logic                  take_best;

  // Effective city count, clamped to the range 1 .. MAX_CITIES.
  always_comb begin
    if (city_count == '0) begin
      n = CNT_W'(1);
    end else if (int'(city_count) > MAX_CITIES) begin
      n = CNT_W'(MAX_CITIES);
    end else begin
      n = CNT_W'(city_count);
    end
  end

  // Load path: keep only upper-triangle entries inside the matrix.
  assign in_accept = in_valid && !in_stall;
  assign wr_en     = in_accept && (row_city < col_city) && (int'(col_city) < MAX_CITIES);
  assign wr_addr   = ADDR_W'(row_city) * ADDR_W'(MAX_CITIES) + ADDR_W'(col_city);

  // Read address for the pair (current city, other city).
  assign pair_other = (state == ST_RET) ? '0 : cand;
  assign pair_lo    = (cur < pair_other) ? cur : pair_other;
  assign pair_hi    = (cur < pair_other) ? pair_other : cur;
  assign rd_addr    = ADDR_W'(pair_lo) * ADDR_W'(MAX_CITIES) + ADDR_W'(pair_hi);

  assign cand_last = (CNT_W'(cand) == n - CNT_W'(1));
  assign out_free  = !out_valid || !out_stall;

  // Closing edge; a single-city tour has none.
  assign ret_len = running_length + ((cur == '0) ? '0 : LEN_W'(rd_data));

  // Running minimum over candidates whose distance has come back from memory.
  assign take_best = s1_valid && s1_elig && (!found || rd_data < bestd);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && last_entry) state_next = ST_START;
      end
      ST_START: begin
        if (out_free) state_next = (n > CNT_W'(1)) ? ST_SCAN : ST_RET;
      end
      ST_SCAN: begin
        if (cand_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_next = (step + CNT_W'(1) < n) ? ST_SCAN : ST_RET;
      end
      ST_RET: begin
        state_next = ST_RET_EMIT;
      end
      ST_RET_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    emit      = 1'b0;
    emit_city = '0;
    emit_len  = '0;
    emit_last = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_START: begin
        emit = out_free;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
      end
      ST_COMMIT: begin
        emit      = out_free;
        emit_city = CITY_W'(best);
      end
      ST_RET: begin
        rd_en = 1'b1;
      end
      ST_RET_EMIT: begin
        emit      = out_free;
        emit_len  = ret_len;
        emit_last = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Distance memory: write on load, registered read during the tour.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= distance;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= COUNT_RESET;
    end else if (cfg_we) begin
      city_count <= cfg_wdata;
    end
  end

  // Sequencer state and the read pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == ST_SCAN);
    end
  end

  // Tour bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      visited        <= '0;
      cur            <= '0;
      step           <= '0;
      running_length <= '0;
      found          <= 1'b0;
      cand           <= '0;
    end else begin
      case (state)
        ST_START: begin
          if (out_free) begin
            visited        <= MAX_CITIES'(1);
            cur            <= '0;
            step           <= CNT_W'(1);
            running_length <= '0;
            found          <= 1'b0;
            cand           <= '0;
          end
        end
        ST_SCAN, ST_WAIT: begin
          if (state == ST_SCAN) cand <= cand + IDX_W'(1);
          if (take_best) found <= 1'b1;
        end
        ST_COMMIT: begin
          if (out_free) begin
            running_length <= running_length + LEN_W'(bestd);
            visited[best]  <= 1'b1;
            cur            <= best;
            step           <= step + CNT_W'(1);
            found          <= 1'b0;
            cand           <= '0;
          end
        end
        default: begin
          cand <= cand;
        end
      endcase
    end
  end

  // Candidate stage and best-so-far payload registers.
  always_ff @(posedge clk) begin
    s1_cand <= cand;
    s1_elig <= (cand != cur) && !visited[cand];
    if (take_best) begin
      best  <= s1_cand;
      bestd <= rd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      city        <= emit_city;
      tour_length <= emit_len;
      last_city   <= emit_last;
    end
  end

  // The closing word always returns to the start city.
  a_last_is_home: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_city |-> city == '0)
    else $error("closing word does not name city 0");

  // Only the closing word carries a length.
  a_len_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_city |-> tour_length == '0)
    else $error("length on a non-closing word");

  // The start city and the current city are marked visited while searching.
  a_cur_visited: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> visited[0] && visited[cur])
    else $error("current city not marked visited");

  // The step count never passes the city count during a tour.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN || state == ST_COMMIT |-> step < n)
    else $error("tour step beyond city count");

  // A commit always has a chosen candidate.
  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> found)
    else $error("commit without a nearest city");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for nearest_neighbor_tour_core: loads distance
// matrices, runs greedy tours and checks every tour word against a predictor.
// Depends on nnt_pkg and the RTL of nearest_neighbor_tour_core only.
module testbench;
  import nnt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CITIES  = 32;
  localparam int DIST_BITS   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 12;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [CITY_W-1:0]    row;
    logic [CITY_W-1:0]    col;
    logic [DIST_BITS-1:0] weight;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic [LEN_W-1:0]  length;
    logic              last;
  } stop_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CITY_W-1:0]    row_city = '0;
  logic [CITY_W-1:0]    col_city = '0;
  logic [DIST_BITS-1:0] distance = '0;
  logic                 last_entry = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CITY_W-1:0]    city;
  logic [LEN_W-1:0]     tour_length;
  logic                 last_city;

  // Predictor state: its own copy of the stored triangle and the city count.
  logic [DIST_BITS-1:0] pair_dist [0:MAX_CITIES-1][0:MAX_CITIES-1];
  logic [COUNT_W-1:0]   count_cfg = COUNT_RESET;
  stop_t                tour_words [$];

  // Stimulus bookkeeping.
  entry_t pending_entries [$];
  entry_t next_word;
  bit     known [0:MAX_CITIES-1][0:MAX_CITIES-1];
  bit     bursts_on = 1'b1;
  int     counted_items = 0;
  int     entries_taken = 0;
  int     tours_planned = 0;
  int     words_checked = 0;
  int     failures = 0;
  int     cycles = 0;
  int     send_gap = 0;
  int     send_calm = 0;
  int     stall_left = 0;
  int     stall_calm = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  stop_t  want;

  nearest_neighbor_tour_core #(
    .MAX_CITIES(MAX_CITIES),
    .DIST_BITS (DIST_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_city   (row_city),
    .col_city   (col_city),
    .distance   (distance),
    .last_entry (last_entry),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .city       (city),
    .tour_length(tour_length),
    .last_city  (last_city)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Distance between two cities as held in the upper triangle.
  function automatic logic [DIST_BITS-1:0] dist_between(int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) return '0;
    return pair_dist[lo][hi];
  endfunction

  // Greedy tour from city 0 at the current count; queues the words it yields.
  function automatic void plan_tour();
    int               n;
    int               here;
    int               best;
    int               cand;
    int               step;
    bit               found;
    bit [MAX_CITIES-1:0] seen;
    logic [DIST_BITS-1:0] best_d;
    logic [DIST_BITS-1:0] d;
    logic [LEN_W-1:0] total;
    stop_t            s;
    n = count_cfg;
    if (n < 1) n = 1;
    if (n > MAX_CITIES) n = MAX_CITIES;
    seen  = 1;
    here  = 0;
    total = '0;
    s = '{city: '0, length: '0, last: 1'b0};
    tour_words = {tour_words, s};
    for (step = 1; step < n; step++) begin
      found  = 1'b0;
      best   = 0;
      best_d = '0;
      for (cand = 0; cand < n; cand++) begin
        if (cand == here || seen[cand]) continue;
        d = dist_between(here, cand);
        // Strictly less keeps the lowest index on a tie.
        if (!found || d < best_d) begin
          found  = 1'b1;
          best   = cand;
          best_d = d;
        end
      end
      total      = total + best_d;
      seen[best] = 1'b1;
      here       = best;
      s = '{city: best[CITY_W-1:0], length: '0, last: 1'b0};
      tour_words = {tour_words, s};
    end
    // A single city has no return leg; the lookup gives zero then.
    total = total + dist_between(here, 0);
    s = '{city: '0, length: total, last: 1'b1};
    tour_words = {tour_words, s};
    tours_planned++;
  endfunction

  // Driver: offers queued words, with random idle bursts while enabled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (row_city < col_city) pair_dist[row_city][col_city] = distance;
        if (last_entry) plan_tour();
        entries_taken++;
        if (send_calm > 0) begin
          send_calm--;
        end else if (bursts_on && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(1, 17);
        end else if ($urandom_range(0, 15) == 0) begin
          send_calm = $urandom_range(10, 40);
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_entries.size() != 0) begin
          next_word  = pending_entries.pop_front();
          in_valid   <= 1'b1;
          row_city   <= next_word.row;
          col_city   <= next_word.col;
          distance   <= next_word.weight;
          last_entry <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver: checks each tour word, drives the stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tour_words.size() == 0) begin
          $error("tour word with nothing expected: city %0d, tour_length %0d, last_city %0d",
                 city, tour_length, last_city);
          failures++;
        end else begin
          want = tour_words.pop_front();
          if (city !== want.city) begin
            $error("city mismatch: expected %0d, got %0d", want.city, city);
            failures++;
          end
          if (tour_length !== want.length) begin
            $error("tour_length mismatch: expected %0d, got %0d", want.length, tour_length);
            failures++;
          end
          if (last_city !== want.last) begin
            $error("last_city mismatch: expected %0d, got %0d", want.last, last_city);
            failures++;
          end
        end
        words_checked++;
      end
      // One long hold while the sender is still offering words.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && words_checked >= 40 && in_valid && in_stall) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_calm > 0) begin
        stall_calm--;
        out_stall <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 31) == 0) stall_calm = $urandom_range(20, 60);
        out_stall <= 1'b0;
      end
    end
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_entry(input int r, input int c, input int d, input bit last);
    entry_t e;
    e = '{row: r[CITY_W-1:0], col: c[CITY_W-1:0], weight: d[DIST_BITS-1:0], last: last};
    pending_entries = {pending_entries, e};
    if (r < c) known[r][c] = 1'b1;
    if (r < c || last) counted_items++;
  endtask

  // Small values make ties common; the extremes turn up regularly.
  function automatic int pick_distance();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 3);
      5, 6, 7:       return $urandom_range(0, 65535);
      8:             return 0;
      default:       return 65535;
    endcase
  endfunction

  // Queues the missing (and some rewritten) entries for n cities, with
  // stray words mixed in, then a closing word that starts the tour.
  task automatic queue_tour(input int n, input int rewrite_pct);
    int pairs [$];
    int lo;
    int hi;
    int i;
    int j;
    int tmp;
    for (lo = 0; lo < n - 1; lo++) begin
      for (hi = lo + 1; hi < n; hi++) begin
        if (!known[lo][hi] || $urandom_range(0, 99) < rewrite_pct)
          pairs = {pairs, lo * MAX_CITIES + hi};
      end
    end
    for (i = pairs.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = pairs[i];
      pairs[i] = pairs[j];
      pairs[j] = tmp;
    end
    foreach (pairs[k]) begin
      if ($urandom_range(0, 4) == 0) begin
        hi = $urandom_range(0, MAX_CITIES - 1);
        if ($urandom_range(0, 1) == 0) begin
          lo = $urandom_range(hi, MAX_CITIES - 1);
          push_entry(lo, hi, $urandom_range(0, 65535), 1'b0);
        end else begin
          lo = $urandom_range(0, MAX_CITIES - 2);
          hi = $urandom_range(lo + 1, MAX_CITIES - 1);
          push_entry(lo, hi, pick_distance(), 1'b0);
        end
      end
      push_entry(pairs[k] / MAX_CITIES, pairs[k] % MAX_CITIES, pick_distance(), 1'b0);
    end
    if ($urandom_range(0, 2) == 0) begin
      hi = $urandom_range(0, MAX_CITIES - 1);
      lo = $urandom_range(hi, MAX_CITIES - 1);
    end else begin
      lo = $urandom_range(0, MAX_CITIES - 2);
      hi = $urandom_range(lo + 1, MAX_CITIES - 1);
    end
    push_entry(lo, hi, pick_distance(), 1'b1);
  endtask

  // Waits until every word is sent and every tour word has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_entries.size() != 0 || in_valid || tour_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[COUNT_W-1:0];
    count_cfg = value[COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed cases, random tours, then a calm closing part.
  initial begin
    int start;
    int pick;
    int cfg_value;
    int n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // One city, from a diagonal word and then a zero count.
    write_count(1);
    push_entry(5, 5, 1234, 1'b1);
    write_count(0);
    push_entry(31, 0, 65535, 1'b1);

    // Two cities at the largest distance.
    write_count(2);
    push_entry(0, 1, 65535, 1'b1);

    // Four cities with a tie out of city 0; lower and diagonal words ignored.
    write_count(4);
    push_entry(0, 1, 5, 1'b0);
    push_entry(0, 2, 5, 1'b0);
    push_entry(3, 0, 1, 1'b0);
    push_entry(0, 3, 9, 1'b0);
    push_entry(1, 2, 0, 1'b0);
    push_entry(31, 31, 0, 1'b0);
    push_entry(1, 3, 7, 1'b0);
    push_entry(30, 31, 65535, 1'b0);
    push_entry(0, 31, 0, 1'b0);
    push_entry(2, 3, 7, 1'b1);
    // Same matrix again, started by an ignored word.
    push_entry(2, 1, 0, 1'b1);

    // Random tours, mostly small, one to three per count setting.
    start = counted_items;
    while (counted_items - start < 290) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)       cfg_value = 0;
      else if (pick == 1)  cfg_value = 1;
      else if (pick < 14)  cfg_value = $urandom_range(2, 6);
      else if (pick < 18)  cfg_value = $urandom_range(7, 12);
      else                 cfg_value = $urandom_range(13, 20);
      n = (cfg_value < 1) ? 1 : cfg_value;
      write_count(cfg_value);
      repeat ($urandom_range(1, 3)) queue_tour(n, 25);
    end

    // Closing part without idling.
    wait_drained();
    bursts_on = 1'b0;
    write_count(12);
    queue_tour(12, 10);
    write_count(3);
    queue_tour(3, 50);

    wait_drained();
    repeat (50) @(posedge clk);
    if (tour_words.size() != 0) begin
      $error("%0d tour words never arrived", tour_words.size());
      failures++;
    end
    $display("Sent %0d matrix words, ran %0d tours of 1 to 20 cities, checked %0d tour words.",
             entries_taken, tours_planned, words_checked);
    $display("Mismatches and stray words: %0d", failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/nnt_pkg.sv
rtl/nearest_neighbor_tour_core.sv
sim/testbench.sv
